### rtl/core/fdpg_pkg.sv
package fdpg_pkg;

    // Widths of the dose period and the shared divider
    localparam int PERIOD_W   = 16;
    localparam int DIVIDEND_W = 24;
    localparam int DIVISOR_W  = 16;
    localparam int RADIX_BITS = 2;
    localparam int DIV_STEPS  = DIVIDEND_W / RADIX_BITS;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    // Input item kinds
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_POWER  = 2'd1;
    localparam logic [1:0] KIND_PERIOD = 2'd2;
    // Unused code: changes nothing, the result is still reported
    localparam logic [1:0] KIND_NONE   = 2'd3;

    // Configuration register indexes (byte address 4*index)
    localparam logic [1:0] REG_PULSE_LEN = 2'd0;
    localparam logic [1:0] REG_ENERGY    = 2'd1;
    localparam logic [1:0] REG_MIN_PER   = 2'd2;
    localparam logic [1:0] REG_MAX_PER   = 2'd3;

    // Configuration reset values
    localparam logic [15:0] PULSE_LEN_RST = 16'd50;
    localparam logic [23:0] ENERGY_RST    = 24'd820512;
    localparam logic [15:0] MIN_PER_RST   = 16'd100;
    localparam logic [15:0] MAX_PER_RST   = 16'd5000;

    // Frequency scaling: twice 1e6 mHz-ms, then round by halving
    localparam logic [DIVIDEND_W-1:0] FREQ_DIVIDEND = 24'd2000000;
    localparam logic [DIVISOR_W-1:0]  KLINE_DIVISOR = 16'd250;

    // Which quotient the shared divider is producing
    typedef enum logic [1:0] {
        DIV_POWER  = 2'd0,
        DIV_FREQ   = 2'd1,
        DIV_ENERGY = 2'd2,
        DIV_KLINE  = 2'd3
    } div_op_t;

endpackage

### rtl/core/fuel_dose_pulse_generator.sv
// Fuel dose pulse generator.
// Input channel (s_valid/s_ready): one transaction per item. kind 0 is a
// one-millisecond tick, kind 1 requests a burn power in watts (period =
// energy_per_dose / watts, clamped to min/max period), kind 2 sets the
// period directly. A period of 0 stops the pump at the start of the next
// pulse. Result channel (m_valid/m_ready): one transaction per item with
// the pump level, the frequency in mHz, the K-line byte and the burn power.
// The APB port holds pulse length, energy per dose and the period clamps.
// Divider: one shared restoring divider, two quotient bits per cycle. A
// power request runs four quotients, a tick or a period set three. An item
// that leaves the pending period at zero skips the figures, after the power
// division when one comes first. s_ready is high only while the sequencer
// is idle, so one item is in work at a time and the next transaction can
// be taken in the cycle after the result load.
// A finished result sits in the output register; the next item is accepted
// while it waits, and its own result waits until the register is taken.
// Reset (aresetn low, synchronous) stops the pulser, drives the pump low,
// clears the pending period and restores the register defaults.
module fuel_dose_pulse_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [15:0] s_watts,
    input  logic [15:0] s_period_ms,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_pump_on,
    output logic [19:0] m_frequency_mhz,
    output logic [7:0]  m_frequency_kline,
    output logic [23:0] m_burn_power,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIV   = 4'b0010,
        ST_APPLY = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    localparam int PW = fdpg_pkg::PERIOD_W;
    localparam int NW = fdpg_pkg::DIVIDEND_W;
    localparam int DW = fdpg_pkg::DIVISOR_W;
    localparam int CW = fdpg_pkg::CNT_W;
    localparam logic [CW-1:0] LAST_STEP = CW'(fdpg_pkg::DIV_STEPS - 1);

    // Configuration registers
    logic [15:0] pulse_len_reg;
    logic [23:0] energy_reg;
    logic [15:0] min_per_reg;
    logic [15:0] max_per_reg;

    // Sequencer and item latches
    state_t            state_reg, state_next;
    fdpg_pkg::div_op_t op_reg, op_next;
    logic [1:0]        kind_reg, kind_next;
    logic [PW-1:0]     req_per_reg, req_per_next;

    // Pulser state
    logic [PW-1:0] ticks_reg, ticks_next;
    logic          next_hi_reg, next_hi_next;
    logic          running_reg, running_next;
    logic [PW-1:0] active_reg, active_next;
    logic [PW-1:0] pending_reg, pending_next;
    logic          level_reg, level_next;

    // Shared divider
    logic [DW-1:0] rem_reg, rem_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] step_rem;
    logic [NW-1:0] step_quo;

    // Result fields and output register
    logic [19:0] freq_reg, freq_next;
    logic [23:0] power_reg, power_next;
    logic [7:0]  kline_reg, kline_next;
    logic        m_valid_reg;
    logic        m_pump_on_reg;
    logic [19:0] m_freq_reg;
    logic [7:0]  m_kline_reg;
    logic [23:0] m_power_reg;
    logic        out_load;

    // Phase change control
    logic          do_phase;
    logic          phase_hi;
    logic [NW:0]   freq_round;
    logic [NW:0]   kline_round;

    // Configuration port
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_len_reg <= fdpg_pkg::PULSE_LEN_RST;
            energy_reg    <= fdpg_pkg::ENERGY_RST;
            min_per_reg   <= fdpg_pkg::MIN_PER_RST;
            max_per_reg   <= fdpg_pkg::MAX_PER_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                fdpg_pkg::REG_PULSE_LEN: pulse_len_reg <= pwdata[15:0];
                fdpg_pkg::REG_ENERGY:    energy_reg    <= pwdata[23:0];
                fdpg_pkg::REG_MIN_PER:   min_per_reg   <= pwdata[15:0];
                fdpg_pkg::REG_MAX_PER:   max_per_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            fdpg_pkg::REG_PULSE_LEN: prdata = {16'd0, pulse_len_reg};
            fdpg_pkg::REG_ENERGY:    prdata = {8'd0, energy_reg};
            fdpg_pkg::REG_MIN_PER:   prdata = {16'd0, min_per_reg};
            fdpg_pkg::REG_MAX_PER:   prdata = {16'd0, max_per_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    // Divider: two restoring steps per cycle
    always_comb begin
        logic [DW:0]   trial;
        logic [DW-1:0] r;
        logic [NW-1:0] q;
        logic          ge;
        r = rem_reg;
        q = quo_reg;
        for (int i = 0; i < fdpg_pkg::RADIX_BITS; i++) begin
            trial = {r, q[NW-1]};
            ge    = (trial >= {1'b0, dvs_reg});
            if (ge) begin
                trial = trial - {1'b0, dvs_reg};
            end
            r = trial[DW-1:0];
            q = {q[NW-2:0], ge};
        end
        step_rem = r;
        step_quo = q;
    end

    assign freq_round  = {1'b0, step_quo} + (NW+1)'(1);
    assign kline_round = {1'b0, step_quo} + (NW+1)'(1);
    assign out_load    = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    assign s_ready     = (state_reg == ST_IDLE);

    // Sequencer, pulser update and divider control
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        kind_next    = kind_reg;
        req_per_next = req_per_reg;
        ticks_next   = ticks_reg;
        next_hi_next = next_hi_reg;
        running_next = running_reg;
        active_next  = active_reg;
        pending_next = pending_reg;
        level_next   = level_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        dvs_next     = dvs_reg;
        cnt_next     = cnt_reg;
        freq_next    = freq_reg;
        power_next   = power_reg;
        kline_next   = kline_reg;
        do_phase     = 1'b0;
        phase_hi     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    kind_next    = s_kind;
                    req_per_next = s_period_ms;
                    state_next   = ST_APPLY;
                    if (s_kind == fdpg_pkg::KIND_POWER) begin
                        if (s_watts != 16'd0) begin
                            // start energy / watts
                            op_next    = fdpg_pkg::DIV_POWER;
                            rem_next   = '0;
                            quo_next   = energy_reg;
                            dvs_next   = s_watts;
                            cnt_next   = '0;
                            state_next = ST_DIV;
                        end else begin
                            req_per_next = '0;
                        end
                    end
                end
            end

            ST_DIV: begin
                rem_next = step_rem;
                quo_next = step_quo;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == LAST_STEP) begin
                    case (op_reg)
                        fdpg_pkg::DIV_POWER: begin
                            // clamp the period to the configured window
                            if (step_quo < {8'd0, min_per_reg}) begin
                                req_per_next = min_per_reg;
                            end else if (step_quo > {8'd0, max_per_reg}) begin
                                req_per_next = max_per_reg;
                            end else begin
                                req_per_next = step_quo[PW-1:0];
                            end
                            state_next = ST_APPLY;
                        end
                        fdpg_pkg::DIV_FREQ: begin
                            freq_next = freq_round[20:1];
                            op_next   = fdpg_pkg::DIV_ENERGY;
                            rem_next  = '0;
                            quo_next  = energy_reg;
                            dvs_next  = pending_reg;
                            cnt_next  = '0;
                        end
                        fdpg_pkg::DIV_ENERGY: begin
                            power_next = step_quo;
                            op_next    = fdpg_pkg::DIV_KLINE;
                            rem_next   = '0;
                            quo_next   = {4'd0, freq_reg};
                            dvs_next   = fdpg_pkg::KLINE_DIVISOR;
                            cnt_next   = '0;
                        end
                        default: begin
                            kline_next = kline_round[8:1];
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end

            ST_APPLY: begin
                unique case (kind_reg) inside
                    fdpg_pkg::KIND_TICK: begin
                        if (running_reg) begin
                            if (ticks_reg > PW'(1)) begin
                                ticks_next = ticks_reg - PW'(1);
                            end else begin
                                ticks_next = '0;
                                do_phase   = 1'b1;
                                phase_hi   = next_hi_reg;
                            end
                        end
                    end
                    fdpg_pkg::KIND_POWER, fdpg_pkg::KIND_PERIOD: begin
                        pending_next = req_per_reg;
                        if (!running_reg) begin
                            running_next = 1'b1;
                            do_phase     = 1'b1;
                            phase_hi     = 1'b1;
                        end
                    end
                    default: ;
                endcase

                // phase change: start a pulse, stop on a zero period, or start the low phase
                if (do_phase) begin
                    if (phase_hi) begin
                        active_next = pending_next;
                        if (pending_next == '0) begin
                            level_next   = 1'b0;
                            running_next = 1'b0;
                            next_hi_next = 1'b1;
                        end else begin
                            level_next   = 1'b1;
                            ticks_next   = (pulse_len_reg != 16'd0) ? pulse_len_reg : PW'(1);
                            next_hi_next = 1'b0;
                        end
                    end else begin
                        level_next   = 1'b0;
                        ticks_next   = (active_reg > pulse_len_reg) ?
                                       (active_reg - pulse_len_reg) : PW'(1);
                        next_hi_next = 1'b1;
                    end
                end

                // start the figures for the pending period, or clear them when it is zero
                if (pending_next != '0) begin
                    op_next    = fdpg_pkg::DIV_FREQ;
                    rem_next   = '0;
                    quo_next   = fdpg_pkg::FREQ_DIVIDEND;
                    dvs_next   = pending_next;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end else begin
                    freq_next  = '0;
                    power_next = '0;
                    kline_next = '0;
                    state_next = ST_OUT;
                end
            end

            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ticks_reg   <= '0;
            next_hi_reg <= 1'b0;
            running_reg <= 1'b0;
            active_reg  <= '0;
            pending_reg <= '0;
            level_reg   <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ticks_reg   <= ticks_next;
            next_hi_reg <= next_hi_next;
            running_reg <= running_next;
            active_reg  <= active_next;
            pending_reg <= pending_next;
            level_reg   <= level_next;
            cnt_reg     <= cnt_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        kind_reg    <= kind_next;
        req_per_reg <= req_per_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        dvs_reg     <= dvs_next;
        freq_reg    <= freq_next;
        power_reg   <= power_next;
        kline_reg   <= kline_next;
        if (out_load) begin
            m_pump_on_reg <= level_reg;
            m_freq_reg    <= freq_reg;
            m_kline_reg   <= kline_reg;
            m_power_reg   <= power_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_pump_on         = m_pump_on_reg;
    assign m_frequency_mhz   = m_freq_reg;
    assign m_frequency_kline = m_kline_reg;
    assign m_burn_power      = m_power_reg;

`ifndef SYNTHESIS
    // A stopped pulser never drives the pump
    a_stopped_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !running_reg |-> !level_reg)
        else $error("pump high while pulser stopped");

    // A high pump always follows a nonzero active period
    a_high_period: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg |-> (active_reg != '0))
        else $error("pump high with zero active period");

    // The divider never runs on a zero divisor
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (dvs_reg != '0))
        else $error("divide by zero");

    // Frequency result stays within 1 kHz
    a_freq_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_freq_reg <= 20'd1000000))
        else $error("frequency out of range");

    // A result register load is followed by a valid result and an idle sequencer
    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (m_valid_reg && (state_reg == ST_IDLE)))
        else $error("result lost after load");
`endif

endmodule
